### rtl/tsc_pkg.sv
// Shared constants and types for the terrain shade colorizer.
// Used by tsc_elev_pipe, terrain_shade_colorizer and the testbench; depends on nothing.
package tsc_pkg;

   // Width of each output color channel; all ones is full intensity.
   localparam int COLOR_BITS = 16;

   // Register stages inside the elevation ramp pipeline.
   localparam int ELEV_LAT = 41;

   // Unity in the Q30 channel format.
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // Indexes of the configuration registers.
   localparam logic [1:0] CSR_SCHEME = 2'd0;
   localparam logic [1:0] CSR_LOW    = 2'd1;
   localparam logic [1:0] CSR_HIGH   = 2'd2;

   // Channel values leaving the elevation pipeline, signed Q30 before clamping.
   typedef struct packed {
      logic signed [31:0] red;
      logic signed [31:0] green;
      logic signed [31:0] blue;
   } elev_chan_type;

endpackage

### rtl/tsc_elev_pipe.sv
// Elevation ramp pipeline: normalizes the elevation, divides, evaluates the sine
// series and forms the three Q30 channels. Depends on tsc_pkg.
module tsc_elev_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [31:0]     elevation,
   input  logic signed [31:0]     low,
   input  logic signed [31:0]     high,
   output logic                   out_valid,
   output tsc_pkg::elev_chan_type chan
);
   import tsc_pkg::*;

   // Stage positions along the pipeline.
   localparam int S_NUM  = 0;
   localparam int S_ABS  = 1;
   localparam int S_FLAG = 2;
   localparam int S_DIV0 = 3;
   localparam int DIV_STAGES = 12;
   localparam int S_T    = S_DIV0 + DIV_STAGES;
   localparam int S_X    = S_T + 1;
   localparam int S_X2   = S_X + 1;
   localparam int S_H0   = S_X2 + 1;
   localparam int H_STEPS = 5;
   localparam int S_Y    = S_H0 + 4 * H_STEPS;
   localparam int S_YP   = S_Y + 1;
   localparam int S_C    = S_YP + 1;

   localparam logic [24:0] T_ONE  = 25'h100_0000;
   localparam logic [24:0] T_HALF = 25'h080_0000;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [28:0] INV_PI_Q30 = 29'd341782638;

   // Divisors of the Horner steps and floor(2^32 / divisor).
   localparam logic [6:0]  H_DIV   [H_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [29:0] H_RECIP [H_STEPS] =
      '{30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};

   typedef struct packed {
      logic signed [32:0] num;
      logic signed [32:0] den;
      logic               zero;
      logic               one;
      logic [31:0]        rem;
      logic [31:0]        dv;
      logic [23:0]        q;
      logic [24:0]        t;
      logic [23:0]        u;
      logic [30:0]        x;
      logic [31:0]        x2;
      logic [30:0]        h;
      logic [31:0]        p;
      logic [61:0]        prod;
      logic [29:0]        qe;
      logic [31:0]        r;
      logic [30:0]        y;
      logic [29:0]        yp;
      logic signed [31:0] c0;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
   } ep_type;

   ep_type                st_ff [ELEV_LAT];
   ep_type                st_in [ELEV_LAT];
   logic [ELEV_LAT-1:0]   vld_ff;
   logic [ELEV_LAT-1:0]   vld_in;

   // Valid bits march with the data whenever the pipeline advances.
   assign vld_in = en ? {vld_ff[ELEV_LAT-2:0], in_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   for (genvar s = 0; s < ELEV_LAT; s++) begin : g_stage
      localparam int IS_H  = (s >= S_H0 && s < S_Y) ? 1 : 0;
      localparam int STEP  = IS_H != 0 ? (s - S_H0) / 4 : 0;
      localparam int PHASE = IS_H != 0 ? (s - S_H0) % 4 : 0;

      if (s == S_NUM) begin : g_first
         // Offsets from the low limit, one bit wider than the operands.
         always_comb begin
            st_in[s]     = st_ff[s];
            st_in[s].num = {elevation[31], elevation} - {low[31], low};
            st_in[s].den = {high[31], high} - {low[31], low};
         end
      end else begin : g_rest
         always_comb begin
            ep_type      nxt;
            logic [63:0] mwide;
            logic [61:0] mrec;
            logic [31:0] qk;
            logic [32:0] r33;
            logic [24:0] tdiff;
            nxt   = st_ff[s-1];
            mwide = '0;
            mrec  = '0;
            qk    = '0;
            r33   = '0;
            tdiff = '0;
            if (s == S_ABS) begin
               // Reversed limits flip both signs so the divisor is positive.
               if (nxt.den[32]) begin
                  nxt.num = -nxt.num;
                  nxt.den = -nxt.den;
               end
            end else if (s == S_FLAG) begin
               nxt.zero = (nxt.den == '0) || nxt.num[32] || (nxt.num == '0);
               nxt.one  = (nxt.num >= nxt.den);
               nxt.rem  = nxt.num[31:0];
               nxt.dv   = nxt.den[31:0];
               nxt.q    = '0;
            end else if (s >= S_DIV0 && s < S_T) begin
               // Two restoring quotient bits per stage.
               for (int i = 0; i < 2; i++) begin
                  r33 = {nxt.rem, 1'b0};
                  if (r33 >= {1'b0, nxt.dv}) begin
                     r33   = r33 - {1'b0, nxt.dv};
                     nxt.q = {nxt.q[22:0], 1'b1};
                  end else begin
                     nxt.q = {nxt.q[22:0], 1'b0};
                  end
                  nxt.rem = r33[31:0];
               end
            end else if (s == S_T) begin
               // Saturated ratio, then fold onto the first quarter wave.
               if (nxt.zero) begin
                  nxt.t = '0;
               end else if (nxt.one) begin
                  nxt.t = T_ONE;
               end else begin
                  nxt.t = {1'b0, nxt.q};
               end
               tdiff = T_ONE - nxt.t;
               nxt.u = (nxt.t > T_HALF) ? tdiff[23:0] : nxt.t[23:0];
            end else if (s == S_X) begin
               mwide = 64'(nxt.u) * 64'(PI_Q30);
               nxt.x = mwide[54:24];
            end else if (s == S_X2) begin
               mwide  = 64'(nxt.x) * 64'(nxt.x);
               nxt.x2 = mwide[61:30];
               nxt.h  = Q30_ONE;
            end else if (IS_H != 0) begin
               // Horner step: h = 1 - floor(floor(x2 * h) / k) over four stages.
               if (PHASE == 0) begin
                  mwide = 64'(nxt.x2) * 64'(nxt.h);
                  nxt.p = mwide[61:30];
               end else if (PHASE == 1) begin
                  mrec     = 62'(nxt.p) * 62'(H_RECIP[STEP]);
                  nxt.prod = mrec;
               end else if (PHASE == 2) begin
                  nxt.qe = nxt.prod[61:32];
                  qk     = 32'(nxt.qe) * 32'(H_DIV[STEP]);
                  nxt.r  = nxt.p - qk;
               end else begin
                  if (nxt.r >= 32'(H_DIV[STEP])) begin
                     nxt.h = Q30_ONE - 31'(nxt.qe) - 31'd1;
                  end else begin
                     nxt.h = Q30_ONE - 31'(nxt.qe);
                  end
               end
            end else if (s == S_Y) begin
               mwide = 64'(nxt.x) * 64'(nxt.h);
               nxt.y = mwide[60:30];
            end else if (s == S_YP) begin
               mwide  = 64'(nxt.y) * 64'(INV_PI_Q30);
               nxt.yp = mwide[59:30];
            end else if (s == S_C) begin
               // Channels from the ramp position and the sine bulge.
               nxt.c0 = $signed({1'b0, nxt.t, 6'b0}) - $signed({2'b0, nxt.yp});
               nxt.c1 = $signed({1'b0, nxt.y});
               nxt.c2 = $signed({1'b0, Q30_ONE}) - $signed({1'b0, nxt.t, 6'b0})
                        - $signed({2'b0, nxt.yp});
            end
            st_in[s] = nxt;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign out_valid  = vld_ff[ELEV_LAT-1];
   assign chan.red   = st_ff[S_C].c0;
   assign chan.green = st_ff[S_C].c1;
   assign chan.blue  = st_ff[S_C].c2;

`ifndef SYNTH
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_T] |-> (st_ff[S_T].t <= T_ONE) && (st_ff[S_T].u <= T_HALF[23:0]))
      else $error("ramp position out of range");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_H0 + 2] |-> st_ff[S_H0 + 2].r < 32'd220)
      else $error("reciprocal quotient off by more than one");

   a_h_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_Y - 1] |-> st_ff[S_Y - 1].h <= Q30_ONE)
      else $error("Horner term out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   a_green_pos: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !chan.green[31])
      else $error("negative sine value");
`endif

endmodule

### rtl/terrain_shade_colorizer.sv
// Top level of the terrain shade colorizer: handshakes, registers, slope gradient,
// sideband delay line, clamping, white blend and output scaling.
// Depends on tsc_pkg and tsc_elev_pipe.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_ready      slopes, elevation, flags
//   rsp      out        rsp_valid / rsp_ready      red, green, blue levels
//   csr      in         csr_wr_en                  csr_index, csr_wdata
//
// One beat enters per cycle while no result waits on rsp_ready; a beat passes the input register,
// the 41-stage elevation pipeline (12 divider stages, five four-stage Horner steps), the
// clamp register and the output register before rsp_valid rises.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// While a result waits on rsp_ready the whole pipeline holds and req_ready is low.
module terrain_shade_colorizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_slope_north,
   input  logic signed [15:0]             req_slope_east,
   input  logic signed [31:0]             req_centroid_elevation,
   input  logic                           req_shape_valid,
   input  logic                           req_holds_no_points,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tsc_pkg::COLOR_BITS-1:0] rsp_red_level,
   output logic [tsc_pkg::COLOR_BITS-1:0] rsp_green_level,
   output logic [tsc_pkg::COLOR_BITS-1:0] rsp_blue_level,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [31:0]                    csr_wdata
);
   import tsc_pkg::*;

   localparam logic signed [16:0] K_SMALL = 17'sd8480;
   localparam logic signed [16:0] K_LARGE = 17'sd31654;
   localparam logic signed [16:0] K_MID   = 17'sd23167;
   localparam logic signed [32:0] K_HALF_Q28 = 33'sd134217728;
   localparam int SB_DEPTH = ELEV_LAT - 1;

   typedef struct packed {
      logic               scheme;
      logic               shape_valid;
      logic               empty;
      logic signed [32:0] n_small;
      logic signed [32:0] e_large;
      logic signed [32:0] n_mid;
      logic signed [32:0] e_mid;
      logic signed [32:0] n_large;
      logic signed [32:0] e_small;
   } grad_prod_type;

   typedef struct packed {
      logic               scheme;
      logic               shape_valid;
      logic               empty;
      logic signed [34:0] g0;
      logic signed [34:0] g1;
      logic signed [34:0] g2;
   } sb_type;

   logic               scheme_ff;
   logic signed [31:0] low_ff;
   logic signed [31:0] high_ff;

   logic               en;
   logic               s0_valid_ff;
   logic signed [15:0] s0_north_ff;
   logic signed [15:0] s0_east_ff;
   logic signed [31:0] s0_elev_ff;
   logic               s0_sv_ff;
   logic               s0_empty_ff;

   grad_prod_type      gp_ff;
   grad_prod_type      gp_in;
   sb_type             sb_ff [SB_DEPTH];
   sb_type             sb_in;

   logic               e_valid;
   elev_chan_type      e_chan;

   logic               f_valid_ff;
   logic [30:0]        f_c_ff [3];
   logic [30:0]        f_c_in [3];

   logic               o_valid_ff;
   logic [COLOR_BITS-1:0] o_lvl_ff [3];
   logic [COLOR_BITS-1:0] o_lvl_in [3];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= 1'b0;
         low_ff    <= 32'sd0;
         high_ff   <= 32'sd1024;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCHEME: scheme_ff <= csr_wdata[0];
            CSR_LOW:    low_ff    <= csr_wdata;
            CSR_HIGH:   high_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The pipeline advances whenever the output register is free or being taken.
   assign en        = !o_valid_ff || rsp_ready;
   assign req_ready = en;

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_north_ff <= req_slope_north;
         s0_east_ff  <= req_slope_east;
         s0_elev_ff  <= req_centroid_elevation;
         s0_sv_ff    <= req_shape_valid;
         s0_empty_ff <= req_holds_no_points;
      end
   end

   tsc_elev_pipe u_elev (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .elevation (s0_elev_ff),
      .low       (low_ff),
      .high      (high_ff),
      .out_valid (e_valid),
      .chan      (e_chan)
   );

   // Gradient products, one multiplier per term.
   always_comb begin
      gp_in.scheme      = scheme_ff;
      gp_in.shape_valid = s0_sv_ff;
      gp_in.empty       = s0_empty_ff;
      gp_in.n_small     = 33'(s0_north_ff * K_SMALL);
      gp_in.e_large     = 33'(s0_east_ff * K_LARGE);
      gp_in.n_mid       = 33'(s0_north_ff * K_MID);
      gp_in.e_mid       = 33'(s0_east_ff * K_MID);
      gp_in.n_large     = 33'(s0_north_ff * K_LARGE);
      gp_in.e_small     = 33'(s0_east_ff * K_SMALL);
   end

   // Gradient sums scaled from Q28 to Q30.
   always_comb begin
      logic signed [34:0] s0;
      logic signed [34:0] s1;
      logic signed [34:0] s2;
      s0 = 35'(K_HALF_Q28) + 35'(gp_ff.n_small) + 35'(gp_ff.e_large);
      s1 = 35'(K_HALF_Q28) + 35'(gp_ff.n_mid) - 35'(gp_ff.e_mid);
      s2 = 35'(K_HALF_Q28) - 35'(gp_ff.n_large) - 35'(gp_ff.e_small);
      sb_in.scheme      = gp_ff.scheme;
      sb_in.shape_valid = gp_ff.shape_valid;
      sb_in.empty       = gp_ff.empty;
      sb_in.g0          = s0 <<< 2;
      sb_in.g1          = s1 <<< 2;
      sb_in.g2          = s2 <<< 2;
   end

   // Sideband delay line, aligned with the elevation pipeline output.
   always_ff @(posedge clock) begin
      if (en) begin
         gp_ff    <= gp_in;
         sb_ff[0] <= sb_in;
         for (int i = 1; i < SB_DEPTH; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   // Channel select, clamp to [0,1] and the white blend.
   always_comb begin
      logic signed [34:0] pre [3];
      logic [31:0]        sum;
      logic [30:0]        cl;
      if (!sb_ff[SB_DEPTH-1].shape_valid) begin
         pre[0] = '0;
         pre[1] = '0;
         pre[2] = '0;
      end else if (sb_ff[SB_DEPTH-1].scheme) begin
         pre[0] = 35'(e_chan.red);
         pre[1] = 35'(e_chan.green);
         pre[2] = 35'(e_chan.blue);
      end else begin
         pre[0] = sb_ff[SB_DEPTH-1].g0;
         pre[1] = sb_ff[SB_DEPTH-1].g1;
         pre[2] = sb_ff[SB_DEPTH-1].g2;
      end
      sum = '0;
      cl  = '0;
      for (int i = 0; i < 3; i++) begin
         if (pre[i] < 35'sd0) begin
            cl = '0;
         end else if (pre[i] > $signed({4'b0, Q30_ONE})) begin
            cl = Q30_ONE;
         end else begin
            cl = pre[i][30:0];
         end
         if (sb_ff[SB_DEPTH-1].empty) begin
            sum       = {1'b0, cl} + {1'b0, Q30_ONE};
            f_c_in[i] = sum[31:1];
         end else begin
            f_c_in[i] = cl;
         end
      end
   end

   // Rounded scaling to the output width with saturation at full intensity.
   always_comb begin
      logic [30+COLOR_BITS:0] scaled;
      logic [COLOR_BITS:0]    lvl;
      scaled = '0;
      lvl    = '0;
      for (int i = 0; i < 3; i++) begin
         scaled = {f_c_ff[i], {COLOR_BITS{1'b0}}} + (31 + COLOR_BITS)'(1 << 29);
         lvl    = scaled[30+COLOR_BITS:30];
         if (lvl[COLOR_BITS]) begin
            o_lvl_in[i] = '1;
         end else begin
            o_lvl_in[i] = lvl[COLOR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid;
         o_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_c_ff   <= f_c_in;
         o_lvl_ff <= o_lvl_in;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_red_level   = o_lvl_ff[0];
   assign rsp_green_level = o_lvl_ff[1];
   assign rsp_blue_level  = o_lvl_ff[2];

`ifndef SYNTH
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      f_valid_ff |-> (f_c_ff[0] <= Q30_ONE) && (f_c_ff[1] <= Q30_ONE)
                     && (f_c_ff[2] <= Q30_ONE))
      else $error("channel escaped the clamp");

   a_black: assert property (@(posedge clock) disable iff (reset)
      en && e_valid && !sb_ff[SB_DEPTH-1].shape_valid && !sb_ff[SB_DEPTH-1].empty
      |=> (f_c_ff[0] == '0) && (f_c_ff[1] == '0) && (f_c_ff[2] == '0))
      else $error("invalid triangle not black");

   a_blend: assert property (@(posedge clock) disable iff (reset)
      en && e_valid && sb_ff[SB_DEPTH-1].empty
      |=> (f_c_ff[0] >= 31'h2000_0000) && (f_c_ff[1] >= 31'h2000_0000)
          && (f_c_ff[2] >= 31'h2000_0000))
      else $error("white blend below half");
`endif

endmodule

### dv/tb_terrain_shade_colorizer.sv
// Self-checking testbench for terrain_shade_colorizer; depends on tsc_pkg and the RTL.
// Directed table, then random beats, checked against table colors or a behavioral predictor.
module tb_terrain_shade_colorizer;
   import tsc_pkg::*;

   // Index that no register answers to.
   localparam logic [1:0] REG_NONE   = 2'd3;
   localparam int         PIPE_LAT   = 44;
   localparam logic [COLOR_BITS-1:0] FULL = '1;
   localparam logic [COLOR_BITS-1:0] ZERO = '0;
   localparam logic [COLOR_BITS-1:0] MID  = {1'b1, {(COLOR_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [15:0] north;
      logic signed [15:0] east;
      logic signed [31:0] elev;
      logic               shape_ok;
      logic               empty;
   } tri_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rgb_type;

   typedef struct packed {
      tri_type item;
      logic    scheme;
      logic    known;
      rgb_type rgb;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [15:0] req_slope_north = 0, req_slope_east = 0;
   logic signed [31:0] req_centroid_elevation = 0;
   logic req_shape_valid = 0, req_holds_no_points = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [COLOR_BITS-1:0] rsp_red_level, rsp_green_level, rsp_blue_level;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;

   terrain_shade_colorizer u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Predictor's copy of the registers.
   logic              cfg_scheme = 0;
   logic signed [63:0] cfg_low = 0, cfg_high = 1024;

   rgb_type expected_colors[$];
   int   mismatches = 0;
   int   send_idle = 0, recv_idle = 0;
   bit   hold_off = 0;

   function automatic logic [63:0] sine_of_turn(logic [63:0] u);
      logic [63:0] x, x2, h;
      logic [63:0] divs[5];
      divs = '{110, 72, 42, 20, 6};
      x  = (u * 64'd3373259426) >> 24;
      x2 = (x * x) >> 30;
      h  = 64'd1 << 30;
      for (int i = 0; i < 5; i++) h = (64'd1 << 30) - ((x2 * h) >> 30) / divs[i];
      return (x * h) >> 30;
   endfunction

   // Works out the color of one triangle under the current registers.
   function automatic rgb_type shade_triangle(tri_type t);
      logic signed [63:0] c[3];
      logic signed [63:0] n, e, num, den, tq, yp;
      logic [63:0] tt, u, y, v;
      rgb_type r;
      n = t.north; e = t.east;
      c = '{0, 0, 0};
      if (t.shape_ok) begin
         if (!cfg_scheme) begin
            c[0] = ((64'sd1 <<< 27) + n * 8480 + e * 31654) * 4;
            c[1] = ((64'sd1 <<< 27) + n * 23167 - e * 23167) * 4;
            c[2] = ((64'sd1 <<< 27) - n * 31654 - e * 8480) * 4;
         end else begin
            num = t.elev - cfg_low;
            den = cfg_high - cfg_low;
            if (den < 0) begin
               num = -num; den = -den;
            end
            if (den == 0 || num <= 0) tt = 0;
            else if (num >= den) tt = 64'd1 << 24;
            else tt = (num << 24) / den;
            u = (tt > (64'd1 << 23)) ? (64'd1 << 24) - tt : tt;
            y = sine_of_turn(u);
            tq = tt << 6;
            yp = ($signed(y) * 64'sd341782638) >>> 30;
            c[0] = tq - yp;
            c[1] = $signed(y);
            c[2] = (64'sd1 <<< 30) - tq - yp;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (c[i] < 0) c[i] = 0;
         if (c[i] > (64'sd1 <<< 30)) c[i] = 64'sd1 <<< 30;
         if (t.empty) c[i] = (c[i] + (64'sd1 <<< 30)) >>> 1;
         v = ((c[i] << COLOR_BITS) + (64'd1 << 29)) >> 30;
         if (v > 64'(FULL)) v = 64'(FULL);
         if (i == 0) r.red = v[COLOR_BITS-1:0];
         else if (i == 1) r.green = v[COLOR_BITS-1:0];
         else r.blue = v[COLOR_BITS-1:0];
      end
      return r;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      if (idx == CSR_SCHEME) cfg_scheme = val[0];
      else if (idx == CSR_LOW) cfg_low = $signed(val);
      else if (idx == CSR_HIGH) cfg_high = $signed(val);
   endtask

   // Stops offering, waits until every expected color has come back, then lets the pipe drain.
   task automatic drain();
      req_valid <= 0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // Offers one beat and holds it until it is taken; valid stays high for a following beat.
   task automatic send_beat(tri_type t, rgb_type exp);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      {req_slope_north, req_slope_east, req_centroid_elevation,
       req_shape_valid, req_holds_no_points} <= t;
      do @(posedge clock); while (!req_ready);
      expected_colors.push_back(exp);
   endtask

   task automatic send_tri(tri_type t);
      send_beat(t, shade_triangle(t));
   endtask

   function automatic tri_type random_tri();
      tri_type t;
      t = tri_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(3))
         0: t.north = $signed(16'($urandom_range(8191))) - 16'sd4096;
         1: t.east  = $signed(16'($urandom_range(8191))) - 16'sd4096;
         default: ;
      endcase
      if ($urandom_range(1))
         t.elev = 32'(cfg_low + $signed(32'($urandom_range(4095))) - 32'sd1024);
      t.shape_ok = $urandom_range(9) != 0;
      t.empty    = $urandom_range(3) == 0;
      return t;
   endfunction

   // Receiver: random stalls, plus one long hold-off.
   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else rsp_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   // Checks each returned color against the oldest expectation.
   always @(posedge clock) begin
      rgb_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h %h",
               rsp_red_level, rsp_green_level, rsp_blue_level);
         end else begin
            exp = expected_colors.pop_front();
            if (exp.red !== rsp_red_level || exp.green !== rsp_green_level ||
                exp.blue !== rsp_blue_level) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("color mismatch: expected %h %h %h, got %h %h %h",
                     exp.red, exp.green, exp.blue,
                     rsp_red_level, rsp_green_level, rsp_blue_level);
            end
         end
      end
   end

   row_type rows[16] = '{
      // Gradient mode: flat, extremes, invalid, empty.
      '{'{16'sd0, 16'sd0, 32'sd0, 1'b1, 1'b0}, 1'b0, 1'b1, '{MID, MID, MID}},
      '{'{16'sd0, 16'sd0, 32'sd0, 1'b0, 1'b0}, 1'b0, 1'b1, '{ZERO, ZERO, ZERO}},
      '{'{16'sd0, 16'sd0, 32'sd0, 1'b0, 1'b1}, 1'b0, 1'b1, '{MID, MID, MID}},
      '{'{16'sh7fff, 16'sh7fff, 32'sd0, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{-16'sd32768, -16'sd32768, 32'sd0, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{16'sh7fff, -16'sd32768, 32'sd0, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
      '{'{-16'sd32768, 16'sh7fff, 32'sd0, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{16'sd1000, -16'sd700, 32'sd0, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      // Elevation mode with default limits 0..1024.
      '{'{16'sd0, 16'sd0, 32'sd0, 1'b1, 1'b0}, 1'b1, 1'b1, '{ZERO, ZERO, FULL}},
      '{'{16'sd0, 16'sd0, 32'sd1024, 1'b1, 1'b0}, 1'b1, 1'b1, '{FULL, ZERO, ZERO}},
      '{'{16'sd0, 16'sd0, -32'sd2147483648, 1'b1, 1'b0}, 1'b1, 1'b1, '{ZERO, ZERO, FULL}},
      '{'{16'sd0, 16'sd0, 32'sh7fffffff, 1'b1, 1'b0}, 1'b1, 1'b1, '{FULL, ZERO, ZERO}},
      '{'{16'sd0, 16'sd0, 32'sd512, 1'b1, 1'b0}, 1'b1, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 32'sd256, 1'b1, 1'b1}, 1'b1, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 32'sd700, 1'b0, 1'b1}, 1'b1, 1'b1, '{MID, MID, MID}},
      '{'{16'sd0, 16'sd0, 32'sd900, 1'b1, 1'b0}, 1'b1, 1'b0, '0}
   };

   // Per random phase: color scheme and limits (default, extremes, gradient,
   // reversed, around zero, equal).
   localparam logic [5:0] PHASE_SCHEME = 6'b111011;
   logic [31:0] lows[6]  = '{32'd0, 32'h8000_0000, 32'd5000, 32'd5000, 32'hffff_fc00,
                             32'd77};
   logic [31:0] highs[6] = '{32'd1024, 32'h7fff_ffff, 32'd1000, 32'd1000, 32'd3, 32'd77};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed table.
      foreach (rows[i]) begin
         if (rows[i].scheme != cfg_scheme) begin
            drain();
            write_reg(CSR_SCHEME, {31'd0, rows[i].scheme});
         end
         if (rows[i].known) send_beat(rows[i].item, rows[i].rgb);
         else send_tri(rows[i].item);
      end
      drain();
      write_reg(REG_NONE, 32'hdead_beef);

      // Random phases over the idling profiles and register settings.
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_reg(CSR_SCHEME, {31'd0, PHASE_SCHEME[ph]});
         write_reg(CSR_LOW, lows[ph]);
         write_reg(CSR_HIGH, highs[ph]);
         send_idle = (ph < 2) ? 36 : (ph < 4) ? 54 : 0;
         recv_idle = (ph < 2) ? 54 : (ph < 4) ? 36 : 0;
         if (ph == 4) fork
            begin
               hold_off = 1;
               repeat (150) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int k = 0; k < 100; k++) send_tri(random_tri());
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatches == 0) $display("[terrain_shade_colorizer] OK");
      else $display("[terrain_shade_colorizer] ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("[terrain_shade_colorizer] ERROR");
      $finish;
   end
endmodule

### files.f
rtl/tsc_pkg.sv
rtl/tsc_elev_pipe.sv
rtl/terrain_shade_colorizer.sv
dv/tb_terrain_shade_colorizer.sv
